@@ hdl/lpf_pkg.sv @@
// lpf_pkg: shared widths, constants, state type and divider interface structs
// for the largest prime factor block; no dependencies
package lpf_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int OUT_WIDTH   = 64;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

  localparam logic [VALUE_WIDTH-1:0] FACTOR_TWO   = VALUE_WIDTH'(2);
  localparam logic [VALUE_WIDTH-1:0] FACTOR_THREE = VALUE_WIDTH'(3);
  localparam logic [VALUE_WIDTH-1:0] VAL_ONE      = VALUE_WIDTH'(1);

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_ZERO = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV,
    ST_DONE
  } lpf_state_t;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quot;
    logic [VALUE_WIDTH-1:0] rem;
  } div_rsp_t;

endpackage

@@ hdl/largest_prime_factor.sv @@
// largest_prime_factor: top level, trial division sequencer with output register
// depends on lpf_pkg and lpf_div
//
//   channel | direction | ports                                  | beat when
//   in      | input     | in_valid, in_stall, in_value           | in_valid & !in_stall
//   out     | output    | out_valid, out_stall, out_largest_factor, out_status
//                                                                 | out_valid & !out_stall
//
// one item at a time; a zero input goes from idle straight to the done state
// factors of two are shifted out in the strip state, then each trial division runs on the serial divider
// trials run over the odd divisors up to the larger of the second-largest prime
// factor and the square root of the largest (the largest itself when it repeats),
// plus one per odd prime factor taken out; the serial divider sets the pace
// reset is synchronous and active low; a stalled output holds its beat while
// the next input beat is taken and worked on
module largest_prime_factor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lpf_pkg::OUT_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lpf_pkg::OUT_WIDTH-1:0] out_largest_factor,
  output logic                          out_status
);

  lpf_pkg::lpf_state_t             state_r, state_nxt;
  logic [lpf_pkg::VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [lpf_pkg::VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [lpf_pkg::VALUE_WIDTH-1:0] best_r, best_nxt;
  logic                            err_r, err_nxt;
  logic [lpf_pkg::VALUE_WIDTH-1:0] out_factor_r, out_factor_nxt;
  logic                            out_status_r, out_status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [lpf_pkg::VALUE_WIDTH-1:0] in_masked;
  lpf_pkg::div_req_t               div_req;
  lpf_pkg::div_rsp_t               div_rsp;

  lpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_masked = in_value[lpf_pkg::VALUE_WIDTH-1:0];
  assign in_stall  = (state_r != lpf_pkg::ST_IDLE);

  always_comb begin
    state_nxt        = state_r;
    q_nxt            = q_r;
    d_nxt            = d_r;
    best_nxt         = best_r;
    err_nxt          = err_r;
    out_factor_nxt   = out_factor_r;
    out_status_nxt   = out_status_r;
    out_valid_nxt    = out_valid_r && out_stall;
    div_req.start    = 1'b0;
    div_req.dividend = q_r;
    div_req.divisor  = d_r;
    case (state_r)
      lpf_pkg::ST_IDLE: begin
        if (in_valid) begin
          best_nxt = '0;
          if (in_masked == '0) begin
            err_nxt   = lpf_pkg::STATUS_ZERO;
            state_nxt = lpf_pkg::ST_DONE;
          end else begin
            err_nxt   = lpf_pkg::STATUS_OK;
            q_nxt     = in_masked;
            state_nxt = lpf_pkg::ST_STRIP;
          end
        end
      end
      lpf_pkg::ST_STRIP: begin
        if (!q_r[0]) begin
          q_nxt    = q_r >> 1;
          best_nxt = lpf_pkg::FACTOR_TWO;
        end else if (q_r == lpf_pkg::VAL_ONE) begin
          state_nxt = lpf_pkg::ST_DONE;
        end else begin
          d_nxt            = lpf_pkg::FACTOR_THREE;
          div_req.start    = 1'b1;
          div_req.divisor  = lpf_pkg::FACTOR_THREE;
          state_nxt        = lpf_pkg::ST_DIV;
        end
      end
      lpf_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            q_nxt    = div_rsp.quot;
            best_nxt = d_r;
            if (div_rsp.quot == lpf_pkg::VAL_ONE) begin
              state_nxt = lpf_pkg::ST_DONE;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = div_rsp.quot;
            end
          end else if (div_rsp.quot < d_r) begin
            best_nxt  = q_r;
            state_nxt = lpf_pkg::ST_DONE;
          end else begin
            d_nxt           = d_r + lpf_pkg::FACTOR_TWO;
            div_req.start   = 1'b1;
            div_req.divisor = d_r + lpf_pkg::FACTOR_TWO;
          end
        end
      end
      lpf_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_factor_nxt = best_r;
          out_status_nxt = err_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = lpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    d_r          <= d_nxt;
    best_r       <= best_nxt;
    err_r        <= err_nxt;
    out_factor_r <= out_factor_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_largest_factor = lpf_pkg::OUT_WIDTH'(out_factor_r);
  assign out_status         = out_status_r;

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == lpf_pkg::ST_DIV)
    else $error("divider result outside trial state");
  a_odd_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lpf_pkg::ST_DIV |-> d_r[0] && d_r >= lpf_pkg::FACTOR_THREE)
    else $error("trial divisor not odd or below three");
  a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_factor_r == '0)
    else $error("rejected input with nonzero factor");
  a_quot_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lpf_pkg::ST_DIV |-> q_r > lpf_pkg::VAL_ONE)
    else $error("trial division on exhausted quotient");
`endif

endmodule

@@ hdl/lpf_div.sv @@
// lpf_div: radix-2 restoring divider, one quotient bit per cycle
// depends on lpf_pkg
module lpf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lpf_pkg::div_req_t req,
  output lpf_pkg::div_rsp_t rsp
);

  logic [lpf_pkg::VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [lpf_pkg::VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [lpf_pkg::VALUE_WIDTH-1:0] divisor_r, divisor_nxt;
  logic [lpf_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [lpf_pkg::VALUE_WIDTH:0]   shifted;
  logic [lpf_pkg::VALUE_WIDTH:0]   diff;

  always_comb begin
    shifted     = {rem_r, quo_r[lpf_pkg::VALUE_WIDTH-1]};
    diff        = shifted - {1'b0, divisor_r};
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    if (req.start) begin
      quo_nxt     = req.dividend;
      rem_nxt     = '0;
      divisor_nxt = req.divisor;
      cnt_nxt     = lpf_pkg::CNT_W'(lpf_pkg::VALUE_WIDTH);
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      if (!diff[lpf_pkg::VALUE_WIDTH]) begin
        rem_nxt = diff[lpf_pkg::VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[lpf_pkg::VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[lpf_pkg::VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[lpf_pkg::VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - lpf_pkg::CNT_W'(1);
      if (cnt_r == lpf_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

`ifndef SYNTHESIS
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with zero bit count");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < divisor_r)
    else $error("partial remainder not below divisor");
`endif

endmodule

@@ tb/lpf_factor_monitor.sv @@
`timescale 1ns / 100ps
// lpf_factor_monitor: watches the in and out channels of largest_prime_factor,
// predicts each result by trial division and compares it field by field
// depends on lpf_pkg
module lpf_factor_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [lpf_pkg::OUT_WIDTH-1:0] in_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [lpf_pkg::OUT_WIDTH-1:0] out_largest_factor,
  input  logic                          out_status,
  output int unsigned                   error_count,
  output int unsigned                   open_count
);

  typedef struct packed {
    logic [lpf_pkg::OUT_WIDTH-1:0] largest_factor;
    logic                          status;
  } factor_result_t;

  factor_result_t awaited_q[$];
  int unsigned    fails = 0;

  function automatic factor_result_t largest_prime_of(logic [lpf_pkg::OUT_WIDTH-1:0] raw);
    logic [lpf_pkg::VALUE_WIDTH-1:0] rest;
    logic [lpf_pkg::VALUE_WIDTH-1:0] trial;
    factor_result_t                  res;
    rest               = raw[lpf_pkg::VALUE_WIDTH-1:0];
    res.largest_factor = '0;
    res.status         = lpf_pkg::STATUS_OK;
    if (rest == '0) begin
      res.status = lpf_pkg::STATUS_ZERO;
      return res;
    end
    while (rest[0] == 1'b0) begin
      res.largest_factor = lpf_pkg::OUT_WIDTH'(lpf_pkg::FACTOR_TWO);
      rest               = rest >> 1;
    end
    trial = lpf_pkg::FACTOR_THREE;
    while (trial <= rest / trial) begin
      while (rest % trial == '0) begin
        res.largest_factor = lpf_pkg::OUT_WIDTH'(trial);
        rest               = rest / trial;
      end
      trial = trial + lpf_pkg::FACTOR_TWO;
    end
    // leftover above one is a prime larger than every divisor taken out
    if (rest > lpf_pkg::VAL_ONE) res.largest_factor = lpf_pkg::OUT_WIDTH'(rest);
    return res;
  endfunction

  always @(posedge clk) begin
    factor_result_t want;
    if (!rst_n) begin
      awaited_q.delete();
      fails = 0;
    end else begin
      if (in_valid && !in_stall) awaited_q.push_back(largest_prime_of(in_value));
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          $error("largest_factor: beat with nothing awaited, actual %0d status %0b",
                 out_largest_factor, out_status);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          if (out_largest_factor !== want.largest_factor) begin
            $error("largest_factor mismatch: expected %0d, actual %0d",
                   want.largest_factor, out_largest_factor);
            fails++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0b, actual %0b", want.status, out_status);
            fails++;
          end
        end
      end
    end
    error_count <= fails;
    open_count  <= awaited_q.size();
  end

endmodule

@@ tb/tb_largest_prime_factor.sv @@
`timescale 1ns / 100ps
// tb_largest_prime_factor: directed and random values into largest_prime_factor with
// random input gaps and output stalls; depends on lpf_pkg, the block and lpf_factor_monitor
module tb_largest_prime_factor;

  localparam int unsigned RANDOM_ITEMS     = 120;
  localparam int unsigned HOLD_CYCLES      = 3000;
  localparam int unsigned DRAIN_CYCLES     = 300;
  localparam int unsigned NUM_SMALL_PRIMES = 31;
  localparam int unsigned SMALL_PRIMES [NUM_SMALL_PRIMES] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53,
    59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127
  };
  localparam logic [lpf_pkg::OUT_WIDTH-1:0] VALUE_MAX = '1;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic [lpf_pkg::OUT_WIDTH-1:0] in_value    = '0;
  logic                          out_stall   = 1'b1;
  logic                          quiet_phase = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic [lpf_pkg::OUT_WIDTH-1:0] out_largest_factor;
  logic                          out_status;
  int unsigned                   error_count;
  int unsigned                   open_count;

  always #4 clk = ~clk;

  largest_prime_factor uut (.*);

  lpf_factor_monitor u_monitor (.*);

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 120);
  endfunction

  task automatic offer_value(input logic [lpf_pkg::OUT_WIDTH-1:0] item);
    int unsigned gap;
    in_valid <= 1'b1;
    in_value <= item;
    do @(posedge clk); while (in_stall);
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_value <= lpf_pkg::OUT_WIDTH'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
  endtask

  // long hold-off first so the block fills up and stalls its input
  initial begin : result_receiver
    int unsigned stall_len;
    wait (rst_n);
    @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall_len = idle_cycles();
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [lpf_pkg::OUT_WIDTH-1:0] v;
    int unsigned                   i, k, p, factor_cnt, prime_cap;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero, one, tiny values, repeated factors, primes, powers of two
    offer_value(lpf_pkg::OUT_WIDTH'(0));
    offer_value(lpf_pkg::OUT_WIDTH'(1));
    offer_value(lpf_pkg::OUT_WIDTH'(2));
    offer_value(lpf_pkg::OUT_WIDTH'(3));
    offer_value(lpf_pkg::OUT_WIDTH'(4));
    offer_value(lpf_pkg::OUT_WIDTH'(9));
    offer_value(lpf_pkg::OUT_WIDTH'(49));
    offer_value(lpf_pkg::OUT_WIDTH'(97 * 89));
    offer_value(lpf_pkg::OUT_WIDTH'(127 * 127 * 127));
    offer_value(lpf_pkg::OUT_WIDTH'(65521));
    offer_value(lpf_pkg::OUT_WIDTH'(1048573));
    offer_value(lpf_pkg::OUT_WIDTH'(65521) << 48);
    offer_value(64'h8000_0000_0000_0000);
    offer_value(64'hC000_0000_0000_0000);
    offer_value(64'hA000_0000_0000_0000);
    v = lpf_pkg::OUT_WIDTH'(1);
    repeat (40) v = v * lpf_pkg::FACTOR_THREE;
    offer_value(v);
    v = lpf_pkg::OUT_WIDTH'(1);
    for (k = 0; k < 15; k++) v = v * SMALL_PRIMES[k];
    offer_value(v);
    offer_value(lpf_pkg::OUT_WIDTH'(0));
    offer_value(lpf_pkg::OUT_WIDTH'(1));

    // mostly smooth products of small primes, some raw small values
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_phase <= (i % 50) >= 38;
      if ($urandom_range(0, 6) == 0) begin
        v = lpf_pkg::OUT_WIDTH'($urandom_range(0, 4095));
      end else begin
        v          = lpf_pkg::OUT_WIDTH'(1);
        prime_cap  = $urandom_range(2, NUM_SMALL_PRIMES - 1);
        factor_cnt = $urandom_range(1, 48);
        for (k = 0; k < factor_cnt; k++) begin
          p = SMALL_PRIMES[$urandom_range(0, prime_cap)];
          if (v > VALUE_MAX / p) break;
          v = v * p;
        end
      end
      offer_value(v);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** largest_prime_factor: PASSED **");
    end else begin
      $display("** largest_prime_factor: FAILED **");
    end
    $finish;
  end

  initial begin : run_limit
    #60_000_000;
    $display("** largest_prime_factor: FAILED **");
    $finish;
  end

endmodule
